### hw/rtl/pot_scan_smoother_macros.svh
// Assertion helpers used by pss_scale.
`ifndef POT_SCAN_SMOOTHER_MACROS_SVH
`define POT_SCAN_SMOOTHER_MACROS_SVH

// Implication in the same cycle, off during reset.
`define PSS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Implication in the next cycle, off during reset.
`define PSS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hw/rtl/pss_pkg.sv
package pss_pkg;

  localparam int SLOT_COUNT   = 8;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);
  localparam int FILTER_SHIFT = 8;
  localparam int KNOB_SHIFT   = 4;

  localparam int SAMPLE_W = 10;
  localparam int GAIN_W   = 6;
  localparam int WHEEL_W  = 14;
  localparam int KNOB_OUT_W = 15;
  localparam int DITHER_W = 32;

  // filter state widths: sample scaled up plus one bit of dither headroom
  localparam int FILT_W = SAMPLE_W + FILTER_SHIFT + 1;
  localparam int FD_W   = FILT_W + 2;
  localparam int KNOB_W = SAMPLE_W + KNOB_SHIFT + 1;
  localparam int KD_W   = KNOB_W + 2;

  localparam int DEV_W  = FILT_W + 1;
  localparam int PROD_W = DEV_W + GAIN_W + 1;

  localparam logic [SAMPLE_W-1:0] CENTER_RESET = SAMPLE_W'(576);
  localparam logic [SAMPLE_W-1:0] THRESH_RESET = SAMPLE_W'(128);
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(24);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_GAIN      = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] center;
    logic [SAMPLE_W-1:0] threshold;
    logic [GAIN_W-1:0]   gain;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    logic [FILTER_SHIFT:0]   dither_f;
    logic [KNOB_SHIFT:0]     dither_k;
    logic [SAMPLE_W-1:0]     pitch;
    logic [SAMPLE_W-1:0]     mod;
    logic [SAMPLE_W-1:0]     knob;
    logic [SAMPLE_W-1:0]     pad_low;
    logic [SAMPLE_W-1:0]     pad_high;
  } sample_stage_t;

  typedef struct packed {
    logic [FILT_W-1:0]     pitch_f;
    logic [FILT_W-1:0]     mod_f;
    logic                  mod_changed;
    logic [SLOT_W-1:0]     slot;
    logic [KNOB_OUT_W-1:0] knob;
    logic [SAMPLE_W-1:0]   pad_low;
    logic [SAMPLE_W-1:0]   pad_high;
  } wheel_stage_t;

  // f += (s*2^FS - f + r) / 2^FS, division truncating toward zero
  function automatic logic [FILT_W-1:0] filt_step(
    input logic [FILT_W-1:0]       f,
    input logic [SAMPLE_W-1:0]     s,
    input logic [FILTER_SHIFT:0]   r
  );
    logic signed [FD_W-1:0] fx;
    logic signed [FD_W-1:0] d;
    logic signed [FD_W-1:0] q;
    logic signed [FD_W-1:0] sum;
    fx  = $signed(FD_W'(f));
    d   = $signed(FD_W'({s, {FILTER_SHIFT{1'b0}}})) - fx + $signed(FD_W'(r));
    q   = d[FD_W-1] ? ((d + $signed(FD_W'((2 ** FILTER_SHIFT) - 1))) >>> FILTER_SHIFT)
                    : (d >>> FILTER_SHIFT);
    sum = fx + q;
    return sum[FILT_W-1:0];
  endfunction

  function automatic logic [KNOB_W-1:0] knob_step(
    input logic [KNOB_W-1:0]     f,
    input logic [SAMPLE_W-1:0]   s,
    input logic [KNOB_SHIFT:0]   r
  );
    logic signed [KD_W-1:0] fx;
    logic signed [KD_W-1:0] d;
    logic signed [KD_W-1:0] q;
    logic signed [KD_W-1:0] sum;
    fx  = $signed(KD_W'(f));
    d   = $signed(KD_W'({s, {KNOB_SHIFT{1'b0}}})) - fx + $signed(KD_W'(r));
    q   = d[KD_W-1] ? ((d + $signed(KD_W'((2 ** KNOB_SHIFT) - 1))) >>> KNOB_SHIFT)
                    : (d >>> KNOB_SHIFT);
    sum = fx + q;
    return sum[KNOB_W-1:0];
  endfunction

  function automatic logic [KNOB_OUT_W-1:0] knob_sat(input logic [KNOB_W-1:0] k);
    return (32'(k) > 32'd32767) ? {KNOB_OUT_W{1'b1}} : KNOB_OUT_W'(k);
  endfunction

  // 8192 - clamp((f - center*2^FS) * gain / 2^FS, -8191, 8192)
  function automatic logic [WHEEL_W-1:0] wheel_scale(
    input logic [FILT_W-1:0]   f,
    input logic [SAMPLE_W-1:0] center,
    input logic [GAIN_W-1:0]   gain
  );
    logic signed [DEV_W-1:0]  dev;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W-1:0] res;
    dev  = $signed(DEV_W'(f)) - $signed(DEV_W'({center, {FILTER_SHIFT{1'b0}}}));
    prod = PROD_W'(dev) * $signed(PROD_W'(gain));
    q    = prod[PROD_W-1]
           ? ((prod + $signed(PROD_W'((2 ** FILTER_SHIFT) - 1))) >>> FILTER_SHIFT)
           : (prod >>> FILTER_SHIFT);
    if (q < $signed(PROD_W'(-8191))) begin
      q = $signed(PROD_W'(-8191));
    end else if (q > $signed(PROD_W'(8192))) begin
      q = $signed(PROD_W'(8192));
    end
    res = $signed(PROD_W'(8192)) - q;
    return res[WHEEL_W-1:0];
  endfunction

endpackage

### hw/rtl/pss_ifs.sv
interface pss_sample_if import pss_pkg::*;;
  logic                valid;
  logic                ready;
  logic [4:0]          slot_tick;
  logic [DITHER_W-1:0] dither_word;
  logic [SAMPLE_W-1:0] pitch_sample;
  logic [SAMPLE_W-1:0] mod_sample;
  logic [SAMPLE_W-1:0] knob_sample;
  logic [SAMPLE_W-1:0] pad_low_sample;
  logic [SAMPLE_W-1:0] pad_high_sample;

  modport source (
    output valid, slot_tick, dither_word, pitch_sample, mod_sample, knob_sample,
           pad_low_sample, pad_high_sample,
    input  ready
  );
  modport sink (
    input  valid, slot_tick, dither_word, pitch_sample, mod_sample, knob_sample,
           pad_low_sample, pad_high_sample,
    output ready
  );
endinterface

interface pss_result_if import pss_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [WHEEL_W-1:0]    pitch_value;
  logic [WHEEL_W-1:0]    mod_value;
  logic                  mod_changed;
  logic [2:0]            slot_index;
  logic [KNOB_OUT_W-1:0] knob_value;
  logic [SAMPLE_W-1:0]   pad_low_value;
  logic [SAMPLE_W-1:0]   pad_high_value;
  logic [2:0]            next_mux_select;

  modport source (
    output valid, pitch_value, mod_value, mod_changed, slot_index, knob_value,
           pad_low_value, pad_high_value, next_mux_select,
    input  ready
  );
  modport sink (
    input  valid, pitch_value, mod_value, mod_changed, slot_index, knob_value,
           pad_low_value, pad_high_value, next_mux_select,
    output ready
  );
endinterface

interface pss_cfg_if import pss_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pss_filter.sv
module pss_filter import pss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pss_sample_if.sink   samples,
  input  cfg_t         cfg,
  input  logic         take,
  output logic         s2_valid,
  output wheel_stage_t s2
);

  logic          s1_valid;
  sample_stage_t s1;
  logic          s1_free;
  logic          s2_free;
  logic          s2_load;
  logic          acting;

  logic [FILT_W-1:0]   pitch_filter;
  logic [FILT_W-1:0]   mod_filter;
  logic [KNOB_W-1:0]   knob_mem [SLOT_COUNT];

  logic [SAMPLE_W-1:0] pitch_in;
  logic                mod_on;
  logic [FILT_W-1:0]   pitch_next;
  logic [FILT_W-1:0]   mod_next;
  logic [KNOB_W-1:0]   knob_next;

  assign s2_free = !s2_valid || take;
  assign s1_free = !s1_valid || s2_free;
  assign s2_load = s1_valid && s2_free;
  assign samples.ready = s1_free;
  assign acting = (samples.slot_tick[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= samples.valid && acting;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && samples.valid) begin
      s1.slot     <= SLOT_W'(32'(samples.slot_tick[4:2]) % SLOT_COUNT);
      s1.dither_f <= samples.dither_word[DITHER_W-1 -: FILTER_SHIFT+1];
      s1.dither_k <= samples.dither_word[DITHER_W-1 -: KNOB_SHIFT+1];
      s1.pitch    <= samples.pitch_sample;
      s1.mod      <= samples.mod_sample;
      s1.knob     <= samples.knob_sample;
      s1.pad_low  <= samples.pad_low_sample;
      s1.pad_high <= samples.pad_high_sample;
    end
  end

  always_comb begin
    pitch_in   = (s1.pitch < cfg.threshold) ? cfg.center : s1.pitch;
    mod_on     = (s1.mod > cfg.threshold);
    pitch_next = filt_step(pitch_filter, pitch_in, s1.dither_f);
    mod_next   = filt_step(mod_filter, s1.mod, s1.dither_f);
    knob_next  = knob_step(knob_mem[s1.slot], s1.knob, s1.dither_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid     <= 1'b0;
      pitch_filter <= '0;
      mod_filter   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        knob_mem[i] <= '0;
      end
    end else begin
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (s2_load) begin
        pitch_filter <= pitch_next;
        if (mod_on) begin
          mod_filter <= mod_next;
        end
        knob_mem[s1.slot] <= knob_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2.pitch_f     <= pitch_next;
      s2.mod_f       <= mod_next;
      s2.mod_changed <= mod_on;
      s2.slot        <= s1.slot;
      s2.knob        <= knob_sat(knob_next);
      s2.pad_low     <= s1.pad_low;
      s2.pad_high    <= s1.pad_high;
    end
  end

endmodule

### hw/rtl/pss_scale.sv
`include "pot_scan_smoother_macros.svh"

module pss_scale import pss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         s2_valid,
  input  wheel_stage_t s2,
  output logic         take,
  pss_result_if.source results
);

  logic                  out_valid;
  logic [WHEEL_W-1:0]    mod_hold;
  logic [WHEEL_W-1:0]    pitch_scaled;
  logic [WHEEL_W-1:0]    mod_scaled;
  logic [SLOT_W-1:0]     slot_next;
  logic                  out_free;

  logic [WHEEL_W-1:0]    pitch_q;
  logic [WHEEL_W-1:0]    mod_q;
  logic                  changed_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     next_q;
  logic [KNOB_OUT_W-1:0] knob_q;
  logic [SAMPLE_W-1:0]   pad_low_q;
  logic [SAMPLE_W-1:0]   pad_high_q;

  assign out_free = !out_valid || results.ready;
  assign take     = s2_valid && out_free;

  always_comb begin
    pitch_scaled = wheel_scale(s2.pitch_f, cfg.center, cfg.gain);
    mod_scaled   = wheel_scale(s2.mod_f, cfg.center, cfg.gain);
    slot_next    = (s2.slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s2.slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mod_hold  <= '0;
    end else begin
      if (out_free) begin
        out_valid <= s2_valid;
      end
      if (take && s2.mod_changed) begin
        mod_hold <= mod_scaled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pitch_q    <= pitch_scaled;
      mod_q      <= s2.mod_changed ? mod_scaled : mod_hold;
      changed_q  <= s2.mod_changed;
      slot_q     <= s2.slot;
      next_q     <= slot_next;
      knob_q     <= s2.knob;
      pad_low_q  <= s2.pad_low;
      pad_high_q <= s2.pad_high;
    end
  end

  assign results.valid           = out_valid;
  assign results.pitch_value     = pitch_q;
  assign results.mod_value       = mod_q;
  assign results.mod_changed     = changed_q;
  assign results.slot_index      = 3'(slot_q);
  assign results.knob_value      = knob_q;
  assign results.pad_low_value   = pad_low_q;
  assign results.pad_high_value  = pad_high_q;
  assign results.next_mux_select = 3'(next_q);

  `PSS_ASSERT_NEXT(a_take_fills, take, out_valid, "taken item did not reach output")
  `PSS_ASSERT_NEXT(a_hold_repeat, take && !s2.mod_changed,
    mod_q == $past(mod_hold), "unchanged mod value does not repeat held value")
  `PSS_ASSERT_NOW(a_hold_tracks, out_valid && changed_q, mod_q == mod_hold,
    "held mod value out of step with recomputed output")

endmodule

### hw/rtl/pot_scan_smoother.sv
// Pot scan smoother: smoothing of pitch and mod wheel, per-slot knob smoothing; pads pass through.
// Channels: samples (one scan tick with dither word and ADC readings), results
// (smoothed wheel values, knob of the slot, pads, next mux select) and cfg
// (register writes: 0 sensor center, 1 active threshold, 2 scale gain; other
// indexes are dropped). cfg is always ready; write it only while idle.
// Every transfer on samples is taken; ticks whose two low bits are not zero
// produce no result and change no filter or knob state.
// Each input transfer passes through the input register, then the filter stage, then
// the scaling multiply into the output register.
// Throughput: one item per cycle while results is ready; the filter state updates
// as each item loads into the filter stage, so consecutive items never wait on each other.
// Reset clears all filters, the held mod value and the knob store, and loads
// the register defaults 576, 128 and 24.
// When results stalls, the output register holds; items keep entering until
// the input and filter stages are also full, then samples.ready drops.
module pot_scan_smoother import pss_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pss_sample_if.sink   samples,
  pss_result_if.source results,
  pss_cfg_if.sink      cfg
);

  cfg_t         cfg_q;
  logic         take;
  logic         s2_valid;
  wheel_stage_t s2;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.center    <= CENTER_RESET;
      cfg_q.threshold <= THRESH_RESET;
      cfg_q.gain      <= GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_e'(cfg.index))
        REG_CENTER:    cfg_q.center    <= cfg.data;
        REG_THRESHOLD: cfg_q.threshold <= cfg.data;
        REG_GAIN:      cfg_q.gain      <= cfg.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pss_filter u_filter (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .cfg      (cfg_q),
    .take     (take),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  pss_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .s2_valid (s2_valid),
    .s2       (s2),
    .take     (take),
    .results  (results)
  );

endmodule
